// File: src/fpes_pkg.sv
// Package for the flash program/erase sequencer.
// Holds the word layouts, bus op and status codes, flash commands and result builders.
// No dependencies.
package fpes_pkg;

    localparam int unsigned ModeW      = 3;
    localparam int unsigned OffsetW    = 18;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned AddrW      = 16;
    localparam int unsigned DelayW     = 20;
    localparam int unsigned BankW      = 2;
    localparam int unsigned PulseW     = 8;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned MaxResults = 7;
    localparam int unsigned CntW       = $clog2(MaxResults + 1);
    localparam int unsigned IdxW       = $clog2(MaxResults);

    // Window of 2^16 bytes, four banks: bank is the two offset bits above the window.
    localparam int unsigned WindowBits = 16;

    localparam logic [ByteW-1:0] CmdProgram       = 8'h40;
    localparam logic [ByteW-1:0] CmdProgramVerify = 8'hc0;
    localparam logic [ByteW-1:0] CmdErase         = 8'h20;
    localparam logic [ByteW-1:0] CmdEraseVerify   = 8'ha0;
    localparam logic [ByteW-1:0] CmdReset         = 8'hff;
    localparam logic [ByteW-1:0] ErasedByte       = 8'hff;

    localparam logic [PulseW-1:0] RstMaxPulses    = 8'd25;
    localparam logic [DelayW-1:0] RstPulseUs      = 20'd50;
    localparam logic [DelayW-1:0] RstVerifyUs     = 20'd30;
    localparam logic [DelayW-1:0] RstEraseGapUs   = 20'd50;
    localparam logic [DelayW-1:0] RstEraseWaitUs  = 20'd10000;
    localparam logic [DelayW-1:0] RstEraseVfyUs   = 20'd50;

    typedef enum logic [ModeW-1:0] {
        MODE_PROGRAM  = 3'd0,
        MODE_ERASE    = 3'd1,
        MODE_EVERIFY  = 3'd2,
        MODE_READBACK = 3'd3,
        MODE_FINISH   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_DELAY  = 3'd2,
        OP_BANK   = 3'd3,
        OP_STATUS = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_OK         = 3'd1,
        ST_PROG_FAIL  = 3'd2,
        ST_NOT_BLANK  = 3'd3,
        ST_UNEXPECTED = 3'd4,
        ST_BUSY       = 3'd5
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_PULSES  = 3'd0,
        CFG_PULSE_US    = 3'd1,
        CFG_VERIFY_US   = 3'd2,
        CFG_ERASE_GAP   = 3'd3,
        CFG_ERASE_WAIT  = 3'd4,
        CFG_ERASE_VFY   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PROG  = 2'd1,
        PH_ERASE = 2'd2
    } t_phase;

    // Input word, read_data highest, mode lowest.
    typedef struct packed {
        logic [ByteW-1:0]   read_data;
        logic [ByteW-1:0]   data;
        logic [OffsetW-1:0] offset;
        logic [ModeW-1:0]   mode;
    } t_item;

    // Result word without tlast, pulses_used highest, op lowest.
    typedef struct packed {
        logic [PulseW-1:0] pulses_used;
        t_status           status;
        logic [BankW-1:0]  bank;
        logic [DelayW-1:0] delay_us;
        logic [ByteW-1:0]  wdata;
        logic [AddrW-1:0]  addr;
        t_op               op;
    } t_res;

    typedef struct packed {
        logic [CntW-1:0]             cnt;
        t_res [MaxResults-1:0]       ent;
    } t_plan;

    localparam int unsigned ItemW = $bits(t_item);
    localparam int unsigned ResW  = $bits(t_res);
    localparam int unsigned InTdataW  = ((ItemW + 7) / 8) * 8;
    localparam int unsigned OutTdataW = ((ResW + 7) / 8) * 8;

    function automatic t_res f_write(input logic [AddrW-1:0] addr, input logic [ByteW-1:0] d);
        t_res r;
        r       = '0;
        r.op    = OP_WRITE;
        r.addr  = addr;
        r.wdata = d;
        return r;
    endfunction

    function automatic t_res f_read(input logic [AddrW-1:0] addr);
        t_res r;
        r      = '0;
        r.op   = OP_READ;
        r.addr = addr;
        return r;
    endfunction

    function automatic t_res f_delay(input logic [DelayW-1:0] us);
        t_res r;
        r          = '0;
        r.op       = OP_DELAY;
        r.delay_us = us;
        return r;
    endfunction

    function automatic t_res f_bank(input logic [BankW-1:0] b);
        t_res r;
        r      = '0;
        r.op   = OP_BANK;
        r.bank = b;
        return r;
    endfunction

    function automatic t_res f_status(input t_status st, input logic [PulseW-1:0] pulses);
        t_res r;
        r             = '0;
        r.op          = OP_STATUS;
        r.status      = st;
        r.pulses_used = pulses;
        return r;
    endfunction

endpackage

// File: src/fpes_ctrl.sv
// Input register, configuration registers, sequencer state and run planner.
// Turns one registered word into the full list of bus operations for its run.
// Depends on fpes_pkg.
module fpes_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    output logic                        o_s_ready,
    input  fpes_pkg::t_item             i_item,
    input  logic                        i_cfg_valid,
    input  logic [fpes_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [fpes_pkg::DelayW-1:0] i_cfg_data,
    output logic                        o_plan_valid,
    output fpes_pkg::t_plan             o_plan,
    input  logic                        i_plan_take
);
    import fpes_pkg::*;

    logic              r_in_valid;
    t_item             r_in;

    logic [PulseW-1:0] r_max_pulses;
    logic [DelayW-1:0] r_pulse_us;
    logic [DelayW-1:0] r_verify_us;
    logic [DelayW-1:0] r_erase_gap;
    logic [DelayW-1:0] r_erase_wait;
    logic [DelayW-1:0] r_erase_vfy;

    t_phase            r_phase,       n_phase;
    logic [PulseW-1:0] r_pulse_count, n_pulse_count;
    logic [ByteW-1:0]  r_pend_byte,   n_pend_byte;
    logic [AddrW-1:0]  r_pend_off,    n_pend_off;
    logic [BankW-1:0]  r_cur_bank,    n_cur_bank;
    logic              r_bank_known,  n_bank_known;

    t_plan             n_plan;
    logic [CntW-1:0]   k;
    logic              do_sel;
    logic              do_pulse;
    logic [AddrW-1:0]  ps_addr;
    logic [ByteW-1:0]  ps_byte;
    logic [BankW-1:0]  bank;
    logic [AddrW-1:0]  woff;
    logic [PulseW-1:0] limit;
    logic              need_sel;

    assign o_s_ready    = !r_in_valid || i_plan_take;
    assign o_plan_valid = r_in_valid;
    assign o_plan       = n_plan;

    assign bank     = r_in.offset[WindowBits +: BankW];
    assign woff     = r_in.offset[AddrW-1:0];
    assign limit    = (r_max_pulses == '0) ? PulseW'(1) : r_max_pulses;
    assign need_sel = !r_bank_known || (r_cur_bank != bank);

    always_comb begin
        n_plan        = '0;
        k             = '0;
        do_sel        = 1'b0;
        do_pulse      = 1'b0;
        ps_addr       = r_pend_off;
        ps_byte       = r_pend_byte;
        n_phase       = r_phase;
        n_pulse_count = r_pulse_count;
        n_pend_byte   = r_pend_byte;
        n_pend_off    = r_pend_off;
        n_cur_bank    = r_cur_bank;
        n_bank_known  = r_bank_known;

        if (r_in.mode <= ModeW'(MODE_FINISH) && r_in.mode != ModeW'(MODE_READBACK)
                && r_phase != PH_IDLE) begin
            n_plan.ent[k] = f_status(ST_BUSY, '0);
            k = k + 1'b1;
        end else begin
            case (t_mode'(r_in.mode))
                MODE_PROGRAM: begin
                    do_sel        = need_sel;
                    do_pulse      = 1'b1;
                    ps_addr       = woff;
                    ps_byte       = r_in.data;
                    n_pend_byte   = r_in.data;
                    n_pend_off    = woff;
                    n_pulse_count = PulseW'(1);
                    n_phase       = PH_PROG;
                end
                MODE_ERASE: begin
                    n_plan.ent[k] = f_write('0, CmdErase);
                    k = k + 1'b1;
                    n_plan.ent[k] = f_delay(r_erase_gap);
                    k = k + 1'b1;
                    n_plan.ent[k] = f_write('0, CmdErase);
                    k = k + 1'b1;
                    n_plan.ent[k] = f_delay(r_erase_wait);
                    k = k + 1'b1;
                    n_plan.ent[k] = f_status(ST_OK, '0);
                    k = k + 1'b1;
                end
                MODE_EVERIFY: begin
                    do_sel     = need_sel;
                    n_pend_off = woff;
                    n_phase    = PH_ERASE;
                end
                MODE_FINISH: begin
                    n_plan.ent[k] = f_write('0, CmdReset);
                    k = k + 1'b1;
                    n_plan.ent[k] = f_bank('0);
                    k = k + 1'b1;
                    n_plan.ent[k] = f_status(ST_OK, '0);
                    k = k + 1'b1;
                    n_cur_bank    = '0;
                    n_bank_known  = 1'b1;
                end
                MODE_READBACK: begin
                    if (r_phase == PH_PROG) begin
                        if (r_in.read_data == r_pend_byte) begin
                            n_plan.ent[k] = f_status(ST_OK, r_pulse_count);
                            k = k + 1'b1;
                            n_phase = PH_IDLE;
                        end else if (r_pulse_count >= limit) begin
                            n_plan.ent[k] = f_write('0, CmdReset);
                            k = k + 1'b1;
                            n_plan.ent[k] = f_status(ST_PROG_FAIL, r_pulse_count);
                            k = k + 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_pulse_count = r_pulse_count + 1'b1;
                            do_pulse      = 1'b1;
                        end
                    end else if (r_phase == PH_ERASE) begin
                        if (r_in.read_data == ErasedByte) begin
                            n_plan.ent[k] = f_status(ST_OK, '0);
                            k = k + 1'b1;
                        end else begin
                            n_plan.ent[k] = f_write('0, CmdReset);
                            k = k + 1'b1;
                            n_plan.ent[k] = f_status(ST_NOT_BLANK, '0);
                            k = k + 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end else begin
                        n_plan.ent[k] = f_status(ST_UNEXPECTED, '0);
                        k = k + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_sel) begin
            n_plan.ent[k] = f_bank(bank);
            k = k + 1'b1;
            n_cur_bank   = bank;
            n_bank_known = 1'b1;
        end

        if (t_mode'(r_in.mode) == MODE_EVERIFY && r_phase == PH_IDLE) begin
            n_plan.ent[k] = f_write(woff, CmdEraseVerify);
            k = k + 1'b1;
            n_plan.ent[k] = f_delay(r_erase_vfy);
            k = k + 1'b1;
            n_plan.ent[k] = f_read(woff);
            k = k + 1'b1;
        end

        if (do_pulse) begin
            n_plan.ent[k] = f_write(ps_addr, CmdProgram);
            k = k + 1'b1;
            n_plan.ent[k] = f_write(ps_addr, ps_byte);
            k = k + 1'b1;
            n_plan.ent[k] = f_delay(r_pulse_us);
            k = k + 1'b1;
            n_plan.ent[k] = f_write(ps_addr, CmdProgramVerify);
            k = k + 1'b1;
            n_plan.ent[k] = f_delay(r_verify_us);
            k = k + 1'b1;
            n_plan.ent[k] = f_read(ps_addr);
            k = k + 1'b1;
        end

        n_plan.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_phase       <= PH_IDLE;
            r_pulse_count <= '0;
            r_pend_byte   <= '0;
            r_pend_off    <= '0;
            r_cur_bank    <= '0;
            r_bank_known  <= 1'b0;
            r_max_pulses  <= RstMaxPulses;
            r_pulse_us    <= RstPulseUs;
            r_verify_us   <= RstVerifyUs;
            r_erase_gap   <= RstEraseGapUs;
            r_erase_wait  <= RstEraseWaitUs;
            r_erase_vfy   <= RstEraseVfyUs;
        end else begin
            if (i_s_valid && o_s_ready) begin
                r_in_valid <= 1'b1;
            end else if (i_plan_take) begin
                r_in_valid <= 1'b0;
            end
            if (i_plan_take) begin
                r_phase       <= n_phase;
                r_pulse_count <= n_pulse_count;
                r_pend_byte   <= n_pend_byte;
                r_pend_off    <= n_pend_off;
                r_cur_bank    <= n_cur_bank;
                r_bank_known  <= n_bank_known;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_PULSES: r_max_pulses <= i_cfg_data[PulseW-1:0];
                    CFG_PULSE_US:   r_pulse_us   <= i_cfg_data;
                    CFG_VERIFY_US:  r_verify_us  <= i_cfg_data;
                    CFG_ERASE_GAP:  r_erase_gap  <= i_cfg_data;
                    CFG_ERASE_WAIT: r_erase_wait <= i_cfg_data;
                    CFG_ERASE_VFY:  r_erase_vfy  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_in <= i_item;
        end
    end

endmodule

// File: src/fpes_emit.sv
// Run buffer and output register for the flash program/erase sequencer.
// Holds one planned run and hands its words out one per cycle while i_ready allows, marking the last.
// Depends on fpes_pkg.
module fpes_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_plan_valid,
    input  fpes_pkg::t_plan i_plan,
    output logic            o_plan_take,
    output logic            o_valid,
    input  logic            i_ready,
    output fpes_pkg::t_res  o_res,
    output logic            o_last
);
    import fpes_pkg::*;

    t_res [MaxResults-1:0] r_buf;
    logic [CntW-1:0]       r_left;
    logic [IdxW-1:0]       r_idx;
    logic                  r_out_valid;
    t_res                  r_out;
    logic                  r_out_last;

    logic move;
    logic can_load;

    assign move        = (!r_out_valid || i_ready) && (r_left != '0);
    assign can_load    = (r_left == '0) || ((r_left == CntW'(1)) && move);
    assign o_plan_take = i_plan_valid && can_load;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_plan_take) begin
                r_left <= i_plan.cnt;
                r_idx  <= '0;
            end else if (move) begin
                r_left <= r_left - 1'b1;
                r_idx  <= r_idx + 1'b1;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_plan_take) begin
            r_buf <= i_plan.ent;
        end
        if (move) begin
            r_out      <= r_buf[r_idx];
            r_out_last <= (r_left == CntW'(1));
        end
    end

endmodule

// File: src/flash_program_erase_sequencer.sv
// Flash program/erase sequencer: each accepted word yields a run of one to seven bus
// operations, delivered one word per cycle on the master side while m_axis_tready is
// high, the last marked by tlast; an unknown mode yields none. The planner register and
// the run buffer are parted, so a new word is taken while the previous run drains. The
// first result passes through the input register, the run buffer and the output
// register. Configuration writes are always ready.
// Depends on fpes_pkg, fpes_ctrl and fpes_emit.
module flash_program_erase_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // mode[2:0], offset[20:3], data[28:21], read_data[36:29], zero pad
    input  logic [fpes_pkg::InTdataW-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // op[2:0], addr[18:3], wdata[26:19], delay_us[46:27], bank[48:47], status[51:49],
    // pulses_used[59:52], zero pad
    output logic [fpes_pkg::OutTdataW-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpes_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [fpes_pkg::DelayW-1:0]    i_cfg_data
);
    import fpes_pkg::*;

    t_item item;
    t_plan plan;
    logic  plan_valid;
    logic  plan_take;
    t_res  res;

    assign item        = t_item'(s_axis_tdata[ItemW-1:0]);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tdata = {{(OutTdataW - ResW){1'b0}}, res};

    fpes_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_item       (item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_plan_valid (plan_valid),
        .o_plan       (plan),
        .i_plan_take  (plan_take)
    );

    fpes_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .i_plan       (plan),
        .o_plan_take  (plan_take),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res        (res),
        .o_last       (m_axis_tlast)
    );

    a_plan_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        plan_valid |-> plan.cnt <= CntW'(MaxResults))
        else $error("planned run longer than the run buffer");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.op == OP_STATUS |-> m_axis_tlast)
        else $error("status word not at end of run");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> res.op == OP_STATUS || res.op == OP_READ)
        else $error("run ends on a word other than status or read");

endmodule
